FILE: rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: shared constants and types of the domino tiling counter
// Profile width limit, count table geometry and the control words passed
// between the sequencer, the update stage and the output stage.
// ----------------------------------------------------------------------------
package dtc_pkg;

  // widest profile (shorter board side) the tables can hold
  localparam int unsigned MAX_WIDTH = 10;

  // board side and count widths
  localparam int unsigned SIDE_W = 8;
  localparam int unsigned CNT_W  = 64;

  // count table: bank bit on top of a MAX_WIDTH-bit profile index
  localparam int unsigned ADDR_W    = MAX_WIDTH + 1;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  // bits for a width value 0..MAX_WIDTH and for the column counter
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);

  // control word that travels with a read into the update stage
  typedef struct packed {
    logic              we;        // a write is due this cycle
    logic              init;      // table initialization write
    logic              init_one;  // initialization value is one
    logic              vert;      // vertical piece allowed (not the first row)
    logic              use_b;     // horizontal piece contributes
    logic              lsb;       // bit 0 of the target profile
    logic [ADDR_W-1:0] addr;      // target entry
  } upd_ctl_t;

  // result hand-off from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic too_wide;
  } res_ctl_t;

endpackage

FILE: rtl/dtc_ram.sv
// ----------------------------------------------------------------------------
// dtc_ram: count table storage
// Both ping-pong banks in one synchronous memory, one write port and two
// read ports with registered read data.
// ----------------------------------------------------------------------------
module dtc_ram (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [dtc_pkg::ADDR_W-1:0]     waddr_i,
  input  logic [dtc_pkg::CNT_W-1:0]      wdata_i,
  input  logic                           re_i,
  input  logic [dtc_pkg::ADDR_W-1:0]     raddr_a_i,
  input  logic [dtc_pkg::ADDR_W-1:0]     raddr_b_i,
  output logic [dtc_pkg::CNT_W-1:0]      rdata_a_o,
  output logic [dtc_pkg::CNT_W-1:0]      rdata_b_o
);

  logic [dtc_pkg::CNT_W-1:0] mem [dtc_pkg::MEM_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

FILE: rtl/dtc_upd.sv
// ----------------------------------------------------------------------------
// dtc_upd: profile count update
// Combines the two source counts read for one target profile and forms the
// write back into the target bank, or the initial table value.
// ----------------------------------------------------------------------------
module dtc_upd (
  input  dtc_pkg::upd_ctl_t              ctl_i,
  input  logic [dtc_pkg::CNT_W-1:0]      rdata_a_i,
  input  logic [dtc_pkg::CNT_W-1:0]      rdata_b_i,
  output logic                           we_o,
  output logic [dtc_pkg::ADDR_W-1:0]     waddr_o,
  output logic [dtc_pkg::CNT_W-1:0]      wdata_o
);

  logic [dtc_pkg::CNT_W-1:0] term_a;
  logic [dtc_pkg::CNT_W-1:0] term_b;

  // gate the vertical and horizontal contributions
  assign term_a = ctl_i.vert  ? rdata_a_i : '0;
  assign term_b = ctl_i.use_b ? rdata_b_i : '0;

  // even target: no piece only; odd target: vertical plus horizontal
  always_comb begin
    if (ctl_i.init) begin
      wdata_o = {{(dtc_pkg::CNT_W-1){1'b0}}, ctl_i.init_one};
    end else if (ctl_i.lsb) begin
      wdata_o = term_a + term_b;
    end else begin
      wdata_o = rdata_a_i;
    end
  end

  assign we_o    = ctl_i.we;
  assign waddr_o = ctl_i.addr;

endmodule

FILE: rtl/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// dtc_ctrl: query sequencer
// Takes a query, initializes the source bank, walks every cell and every
// target profile issuing table reads, then fetches the final count.
// ----------------------------------------------------------------------------
module dtc_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dtc_pkg::SIDE_W-1:0]       board_rows_i,
  input  logic [dtc_pkg::SIDE_W-1:0]       board_cols_i,
  input  logic                             out_free_i,
  output logic                             re_o,
  output logic [dtc_pkg::ADDR_W-1:0]       raddr_a_o,
  output logic [dtc_pkg::ADDR_W-1:0]       raddr_b_o,
  output dtc_pkg::upd_ctl_t                ctl_o,
  output dtc_pkg::res_ctl_t                res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_IWAIT = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_CWAIT = 3'd4;
  localparam logic [2:0] ST_FETCH = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                        state_q, state_d;
  logic [dtc_pkg::WCNT_W-1:0]        w_q, w_d;
  logic [dtc_pkg::SIDE_W-1:0]        len_q, len_d;
  logic [dtc_pkg::MAX_WIDTH-1:0]     full_q, full_d;
  logic [dtc_pkg::MAX_WIDTH-1:0]     top_q, top_d;
  logic [dtc_pkg::MAX_WIDTH-1:0]     m_q, m_d;
  logic [dtc_pkg::SIDE_W-1:0]        i_q, i_d;
  logic [dtc_pkg::WCNT_W-1:0]        j_q, j_d;
  logic                              cur_q, cur_d;
  logic                              last_q, last_d;
  logic                              tw_q, tw_d;
  dtc_pkg::upd_ctl_t                 ctl_q, ctl_d;

  logic [dtc_pkg::SIDE_W-1:0]        side_min;
  logic [dtc_pkg::SIDE_W-1:0]        side_max;
  logic [dtc_pkg::MAX_WIDTH-1:0]     full_new;
  logic [dtc_pkg::MAX_WIDTH-1:0]     top_new;
  logic [dtc_pkg::MAX_WIDTH-1:0]     m_shr;
  logic [dtc_pkg::MAX_WIDTH-1:0]     low_a;
  logic [dtc_pkg::MAX_WIDTH-1:0]     low_b;
  logic                              m_last;
  logic                              j_last;

  // shorter side is the profile width
  assign side_min = (board_rows_i < board_cols_i) ? board_rows_i : board_cols_i;
  assign side_max = (board_rows_i < board_cols_i) ? board_cols_i : board_rows_i;

  // all-ones mask and top bit of the profile for the new width
  always_comb begin
    for (int b = 0; b < dtc_pkg::MAX_WIDTH; b++) begin
      full_new[b] = side_min > dtc_pkg::SIDE_W'(b);
      top_new[b]  = side_min == dtc_pkg::SIDE_W'(b + 1);
    end
  end

  // source entries feeding target profile m
  assign m_shr  = m_q >> 1;
  assign low_a  = m_q[0] ? m_shr : (m_shr | top_q);
  assign low_b  = {m_shr[dtc_pkg::MAX_WIDTH-1:1], 1'b0} | top_q;
  assign m_last = (m_q == full_q);
  assign j_last = (j_q == w_q - dtc_pkg::WCNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    len_d   = len_q;
    full_d  = full_q;
    top_d   = top_q;
    m_d     = m_q;
    i_d     = i_q;
    j_d     = j_q;
    cur_d   = cur_q;
    last_d  = last_q;
    tw_d    = tw_q;
    ctl_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          len_d  = side_max;
          w_d    = side_min[dtc_pkg::WCNT_W-1:0];
          full_d = full_new;
          top_d  = top_new;
          m_d    = '0;
          i_d    = '0;
          j_d    = '0;
          cur_d  = 1'b0;
          if (side_min > dtc_pkg::SIDE_W'(dtc_pkg::MAX_WIDTH)) begin
            tw_d    = 1'b1;
            state_d = ST_OUT;
          end else begin
            tw_d    = 1'b0;
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ctl_d.we       = 1'b1;
        ctl_d.init     = 1'b1;
        ctl_d.init_one = m_last;
        ctl_d.addr     = {1'b0, m_q};
        if (m_last) begin
          m_d     = '0;
          state_d = ST_IWAIT;
        end else begin
          m_d = m_q + dtc_pkg::MAX_WIDTH'(1);
        end
      end
      ST_IWAIT: begin
        state_d = (w_q == '0) ? ST_FETCH : ST_RUN;
      end
      ST_RUN: begin
        ctl_d.we    = 1'b1;
        ctl_d.lsb   = m_q[0];
        ctl_d.vert  = (i_q != '0);
        ctl_d.use_b = m_q[0] & m_shr[0] & (j_q != '0);
        ctl_d.addr  = {~cur_q, m_q};
        if (m_last) begin
          m_d     = '0;
          last_d  = j_last && (i_q == len_q - dtc_pkg::SIDE_W'(1));
          state_d = ST_CWAIT;
          if (j_last) begin
            j_d = '0;
            i_d = i_q + dtc_pkg::SIDE_W'(1);
          end else begin
            j_d = j_q + dtc_pkg::WCNT_W'(1);
          end
        end else begin
          m_d = m_q + dtc_pkg::MAX_WIDTH'(1);
        end
      end
      ST_CWAIT: begin
        // last write of the cell lands now; swap banks
        cur_d   = ~cur_q;
        state_d = last_q ? ST_FETCH : ST_RUN;
      end
      ST_FETCH: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= 1'b0;
      last_q  <= 1'b0;
      tw_q    <= 1'b0;
      ctl_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
      tw_q    <= tw_d;
      ctl_q   <= ctl_d;
    end
  end

  // query geometry and loop counters
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    len_q  <= len_d;
    full_q <= full_d;
    top_q  <= top_d;
    m_q    <= m_d;
    i_q    <= i_d;
    j_q    <= j_d;
  end

  // table reads: profile walk, then the final count
  assign re_o      = (state_q == ST_RUN) || (state_q == ST_FETCH);
  assign raddr_a_o = (state_q == ST_FETCH) ? {cur_q, full_q} : {cur_q, low_a};
  assign raddr_b_o = {cur_q, low_b};

  assign ctl_o        = ctl_q;
  assign res_o.load   = (state_q == ST_OUT) && out_free_i;
  assign res_o.too_wide = tw_q;
  assign in_stall_o   = (state_q != ST_IDLE);

endmodule

FILE: rtl/domino_tiling_counter.sv
// ----------------------------------------------------------------------------
// domino_tiling_counter: domino tiling count by broken-profile DP
// Counts the 1x2 domino tilings of a rows x cols board modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) moves one word: board_rows_i and
//   board_cols_i. Output channel (out_valid_o / out_stall_i) returns one word
//   per query: tiling_count_o and too_wide_o. A word moves at a clock edge
//   with valid high and stall low.
//   The count table is walked one profile entry per cycle, set by the
//   single write port of the table memory, with a turnaround state after
//   each cell in which the banks swap. A shorter side above MAX_WIDTH is
//   answered without a table walk, with too_wide_o set and a zero count.
//   One query is worked at a time; the next is taken as soon as the result
//   sits in the output register, even while the receiver stalls it. A held
//   result plus a finished query stalls the input until the output drains.
//   Reset clears the control state and the output valid; the count table
//   needs no clearing since each query initializes it before use.
// ----------------------------------------------------------------------------
module domino_tiling_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dtc_pkg::SIDE_W-1:0]   board_rows_i,
  input  logic [dtc_pkg::SIDE_W-1:0]   board_cols_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dtc_pkg::CNT_W-1:0]    tiling_count_o,
  output logic                         too_wide_o
);

  logic                          out_valid_q;
  logic [dtc_pkg::CNT_W-1:0]     count_q;
  logic                          tw_q;
  logic                          out_free;
  logic                          re;
  logic [dtc_pkg::ADDR_W-1:0]    raddr_a;
  logic [dtc_pkg::ADDR_W-1:0]    raddr_b;
  logic [dtc_pkg::CNT_W-1:0]     rdata_a;
  logic [dtc_pkg::CNT_W-1:0]     rdata_b;
  logic                          we;
  logic [dtc_pkg::ADDR_W-1:0]    waddr;
  logic [dtc_pkg::CNT_W-1:0]     wdata;
  dtc_pkg::upd_ctl_t             ctl;
  dtc_pkg::res_ctl_t             res;

  assign out_free = !out_valid_q || !out_stall_i;

  dtc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .board_rows_i (board_rows_i),
    .board_cols_i (board_cols_i),
    .out_free_i   (out_free),
    .re_o         (re),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .ctl_o        (ctl),
    .res_o        (res)
  );

  dtc_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  dtc_upd u_upd (
    .ctl_i     (ctl),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata)
  );

  // output valid: set on load, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word, held while stalled
  always_ff @(posedge clk_i) begin
    if (res.load) begin
      count_q <= res.too_wide ? '0 : rdata_a;
      tw_q    <= res.too_wide;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tiling_count_o = count_q;
  assign too_wide_o     = tw_q;

endmodule

FILE: rtl/dtc_chk.sv
// ----------------------------------------------------------------------------
// dtc_chk: port checker for the domino tiling counter
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
module dtc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [dtc_pkg::SIDE_W-1:0]   board_rows_i,
  input logic [dtc_pkg::SIDE_W-1:0]   board_cols_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [dtc_pkg::CNT_W-1:0]    tiling_count_o,
  input logic                         too_wide_o
);

  // an oversized board reports a zero count
  a_too_wide_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_wide_o |-> tiling_count_o == '0)
    else $error("too_wide result with nonzero count");

  // one query in flight: the input closes right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open in the cycle after an accepted word");

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(tiling_count_o) && $stable(too_wide_o))
    else $error("result changed while stalled");

endmodule

bind domino_tiling_counter dtc_chk u_dtc_chk (.*);

FILE: tb/sv/domino_tiling_checker.sv
// ----------------------------------------------------------------------------
// domino_tiling_checker: result checker for the domino tiling counter
// Watches both channels. Works out the tiling count of every accepted query
// and compares each returned word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module domino_tiling_checker
  import dtc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [SIDE_W-1:0] board_rows_i,
  input  logic [SIDE_W-1:0] board_cols_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [CNT_W-1:0]  tiling_count_i,
  input  logic              too_wide_i,
  output int unsigned       pending_o,
  output int unsigned       failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             too_wide;
  } tiling_result_t;

  localparam int unsigned PROFILES = 1 << MAX_WIDTH;

  tiling_result_t tilings_due [$];

  // Count tilings of a len x w strip, one cell at a time over the profile.
  function automatic logic [CNT_W-1:0] count_tilings(input int unsigned w,
                                                      input int unsigned len);
    logic [CNT_W-1:0] cur_cnt [PROFILES];
    logic [CNT_W-1:0] nxt_cnt [PROFILES];
    logic [CNT_W-1:0] v;
    int unsigned      full;
    int unsigned      top;
    full = (1 << w) - 1;
    top  = (w != 0) ? (1 << (w - 1)) : 0;
    for (int unsigned k = 0; k <= full; k++) cur_cnt[k] = '0;
    // start from a fully covered profile
    cur_cnt[full] = CNT_W'(1);
    for (int unsigned row = 0; row < len; row++) begin
      for (int unsigned col = 0; col < w; col++) begin
        for (int unsigned k = 0; k <= full; k++) nxt_cnt[k] = '0;
        for (int unsigned k = 0; k <= full; k++) begin
          v = cur_cnt[k];
          // leave the cell empty: the cell dropping out must be covered
          if ((k & top) != 0) nxt_cnt[(k << 1) & full] += v;
          // vertical piece into the open cell above
          if (row != 0 && (k & top) == 0) nxt_cnt[((k << 1) | 1) & full] += v;
          // horizontal piece into the open cell to the left
          if (col != 0 && (k & 1) == 0 && (k & top) != 0)
            nxt_cnt[((k << 1) ^ 3) & full] += v;
        end
        cur_cnt = nxt_cnt;
      end
    end
    return cur_cnt[full];
  endfunction

  function automatic tiling_result_t predict_tiling(input logic [SIDE_W-1:0] rows,
                                                    input logic [SIDE_W-1:0] cols);
    tiling_result_t res;
    int unsigned    short_side;
    int unsigned    long_side;
    short_side = (rows > cols) ? 32'(cols) : 32'(rows);
    long_side  = (rows > cols) ? 32'(rows) : 32'(cols);
    if (short_side > MAX_WIDTH) begin
      res.count    = '0;
      res.too_wide = 1'b1;
    end else begin
      res.count    = count_tilings(short_side, long_side);
      res.too_wide = 1'b0;
    end
    return res;
  endfunction

  // Sample at the falling edge: values hold until the next rising edge.
  always @(negedge clk_i) begin
    tiling_result_t want;
    if (!rst_ni) begin
      pending_o  = 0;
      failures_o = 0;
    end else begin
      // check a returned word against the oldest query
      if (out_valid_i && !out_stall_i) begin
        if (tilings_due.size() == 0) begin
          $error("unexpected result word: tiling_count %0d, too_wide %0b",
                 tiling_count_i, too_wide_i);
          failures_o++;
        end else begin
          want = tilings_due.pop_front();
          if (tiling_count_i !== want.count) begin
            $error("tiling_count mismatch: expected %0d, actual %0d",
                   want.count, tiling_count_i);
            failures_o++;
          end
          if (too_wide_i !== want.too_wide) begin
            $error("too_wide mismatch: expected %0b, actual %0b",
                   want.too_wide, too_wide_i);
            failures_o++;
          end
        end
      end
      // queue the answer for an accepted query
      if (in_valid_i && !in_stall_i)
        tilings_due.push_back(predict_tiling(board_rows_i, board_cols_i));
      pending_o = tilings_due.size();
    end
  end

endmodule

FILE: tb/sv/domino_tiling_counter_tb.sv
// ----------------------------------------------------------------------------
// domino_tiling_counter_tb: testbench top for the domino tiling counter
// Sends directed board shapes (empty, odd, too wide, wrapping counts, full
// profile width) and then random shapes, mostly narrow, with random gaps on
// the sender and random stalls on the receiver. A checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module domino_tiling_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtc_pkg::*;

  localparam int unsigned RANDOM_QUERIES = 80;
  localparam int unsigned QUIET_TAIL     = 15;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [SIDE_W-1:0] board_rows;
  logic [SIDE_W-1:0] board_cols;
  logic              out_valid;
  logic              out_stall;
  logic [CNT_W-1:0]  tiling_count;
  logic              too_wide;
  int unsigned       pending;
  int unsigned       failures;
  bit                tail_quiet;

  domino_tiling_counter i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .board_rows_i   (board_rows),
    .board_cols_i   (board_cols),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tiling_count_o (tiling_count),
    .too_wide_o     (too_wide)
  );

  domino_tiling_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .board_rows_i   (board_rows),
    .board_cols_i   (board_cols),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tiling_count_i (tiling_count),
    .too_wide_i     (too_wide),
    .pending_o      (pending),
    .failures_o     (failures)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hold off now and then, then send one query and wait for it to be taken.
  task automatic send_query(input logic [SIDE_W-1:0] rows,
                            input logic [SIDE_W-1:0] cols);
    bit          taken;
    int unsigned gap;
    gap = 0;
    if (!tail_quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid   <= 1'b0;
      board_rows <= SIDE_W'($urandom);
      board_cols <= SIDE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    board_rows <= rows;
    board_cols <= cols;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Drop valid and hold until every queued answer has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stall bursts, with calm stretches between.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (tail_quiet) begin
          calm_left = 0;
        end else if (calm_left != 0) begin
          calm_left--;
        end else if ($urandom_range(0, 31) == 0) begin
          calm_left = $urandom_range(20, 200);
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = $urandom_range(1, 4);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned       kind;
    int unsigned       short_side;
    int unsigned       long_side;
    logic [SIDE_W-1:0] rows;
    logic [SIDE_W-1:0] cols;
    tail_quiet = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    board_rows <= '0;
    board_cols <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty boards: a zero side gives the single empty tiling
    send_query(8'd0, 8'd0);
    send_query(8'd0, 8'd255);
    send_query(8'd255, 8'd0);
    // too wide: shorter side past the profile limit
    send_query(8'd255, 8'd255);
    send_query(8'd11, 8'd11);
    send_query(8'd200, 8'd11);
    // odd area yields zero
    send_query(8'd1, 8'd1);
    send_query(8'd3, 8'd3);
    send_query(8'd1, 8'd255);
    // narrow strips
    send_query(8'd1, 8'd2);
    send_query(8'd2, 8'd1);
    send_query(8'd10, 8'd1);
    // long strips whose counts wrap past 64 bits
    send_query(8'd2, 8'd255);
    send_query(8'd254, 8'd3);
    send_query(8'd4, 8'd255);
    // mixed vertical and horizontal placement, up to the full profile width
    send_query(8'd6, 8'd7);
    send_query(8'd5, 8'd10);
    send_query(8'd8, 8'd8);
    send_query(8'd9, 8'd10);
    send_query(8'd10, 8'd10);
    send_query(8'd11, 8'd10);

    // let the block go fully idle before the random part
    drain_results();

    for (int unsigned n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == RANDOM_QUERIES - QUIET_TAIL) tail_quiet = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        short_side = $urandom_range(MAX_WIDTH + 1, 255);
        long_side  = $urandom_range(short_side, 255);
      end else if (kind < 5) begin
        short_side = $urandom_range(5, 7);
        long_side  = $urandom_range(short_side, 31);
      end else begin
        short_side = $urandom_range(0, 4);
        long_side  = $urandom_range(short_side, 255);
      end
      if ($urandom_range(0, 1) == 1) begin
        rows = SIDE_W'(short_side);
        cols = SIDE_W'(long_side);
      end else begin
        rows = SIDE_W'(long_side);
        cols = SIDE_W'(short_side);
      end
      send_query(rows, cols);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #250ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/dtc_pkg.sv
rtl/dtc_ram.sv
rtl/dtc_upd.sv
rtl/dtc_ctrl.sv
rtl/domino_tiling_counter.sv
rtl/dtc_chk.sv
tb/sv/domino_tiling_checker.sv
tb/sv/domino_tiling_counter_tb.sv
